>>> src/lfpat_pkg.sv
package lfpat_pkg;

   localparam int TABLE_DEPTH_DEFAULT      = 1024;
   localparam int GENERATION_WIDTH_DEFAULT = 32;
   localparam int OPERATION_WIDTH          = 2;
   localparam int ENTRY_INDEX_WIDTH        = 10;
   localparam int VALUE_WIDTH              = 64;

   typedef enum logic [OPERATION_WIDTH-1:0] {
      OP_FILL = 2'd0,
      OP_ADD  = 2'd1,
      OP_READ = 2'd2
   } op_type;

   // Signed addition that clamps to the most negative or most positive value.
   function automatic logic [VALUE_WIDTH-1:0] sat_add(
      input logic [VALUE_WIDTH-1:0] a,
      input logic [VALUE_WIDTH-1:0] b
   );
      logic [VALUE_WIDTH-1:0] s;
      logic [VALUE_WIDTH-1:0] limit;
      s = a + b;
      limit = {a[VALUE_WIDTH-1], {(VALUE_WIDTH-1){~a[VALUE_WIDTH-1]}}};
      if ((a[VALUE_WIDTH-1] == b[VALUE_WIDTH-1]) && (s[VALUE_WIDTH-1] != a[VALUE_WIDTH-1])) begin
         return limit;
      end
      return s;
   endfunction

endpackage

>>> src/lfpat_ram.sv
module lfpat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the entry being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lazy_fill_point_add_table.sv
// Channel | Direction | Handshake             | Payload
// req_    | in        | req_valid / req_stall | operation, entry_index, operand_value
// rsp_    | out       | rsp_valid / rsp_stall | read_value, generation_wrapped
//
// One operation is taken per cycle while req_stall is low; a read result passes from the second stage
// into the response register, and the single table memory port pair of one read and one write sets that rate.
// After reset a clearing pass writes every entry with req_stall high.
// Only reads produce a response; fills, adds and unknown operations produce none.
// A read held by rsp_stall waits in the second stage and holds req_stall high.
module lazy_fill_point_add_table #(
   parameter int TABLE_DEPTH      = lfpat_pkg::TABLE_DEPTH_DEFAULT,
   parameter int GENERATION_WIDTH = lfpat_pkg::GENERATION_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [lfpat_pkg::OPERATION_WIDTH-1:0]    req_operation,
   input  logic [lfpat_pkg::ENTRY_INDEX_WIDTH-1:0]  req_entry_index,
   input  logic signed [lfpat_pkg::VALUE_WIDTH-1:0] req_operand_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [lfpat_pkg::VALUE_WIDTH-1:0] rsp_read_value,
   output logic                                     rsp_generation_wrapped
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int IW = lfpat_pkg::ENTRY_INDEX_WIDTH;
   localparam int EW = (AW > IW) ? AW : IW;
   localparam int VW = lfpat_pkg::VALUE_WIDTH;
   localparam int GW = GENERATION_WIDTH;
   localparam int MW = VW + GW;
   localparam int OW = lfpat_pkg::OPERATION_WIDTH;

   logic [EW-1:0] req_index_ext;
   logic [AW-1:0] req_addr;
   logic          req_in_range;
   logic          accept;

   logic          clear_active_ff, clear_active_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;

   logic          s1_valid_ff, s1_valid_in;
   logic [OW-1:0] s1_op_ff, s1_op_in;
   logic [AW-1:0] s1_addr_ff, s1_addr_in;
   logic          s1_in_range_ff, s1_in_range_in;
   logic [VW-1:0] s1_operand_ff, s1_operand_in;

   logic          fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0] fwd_addr_ff, fwd_addr_in;
   logic [MW-1:0] fwd_data_ff, fwd_data_in;

   logic [GW-1:0] gen_count_ff, gen_count_in;
   logic [VW-1:0] fill_value_ff, fill_value_in;
   logic          wrap_flag_ff, wrap_flag_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_wrapped_ff, rsp_wrapped_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [MW-1:0] ram_wdata;
   logic [MW-1:0] ram_rdata;

   logic [MW-1:0] stored;
   logic [GW-1:0] stored_gen;
   logic [VW-1:0] stored_val;
   logic          fresh;
   logic [VW-1:0] add_sum;
   logic [VW-1:0] read_result;
   logic          s1_done;
   logic          s1_write;

   assign req_index_ext = EW'(req_entry_index);
   assign req_addr      = req_index_ext[AW-1:0];
   assign req_in_range  = 32'(req_entry_index) < TABLE_DEPTH;

   assign s1_done   = s1_valid_ff &&
                      ((s1_op_ff != lfpat_pkg::OP_READ) || !rsp_valid_ff || !rsp_stall);
   assign s1_write  = s1_done && (s1_op_ff == lfpat_pkg::OP_ADD) && s1_in_range_ff;
   assign req_stall = clear_active_ff || (s1_valid_ff && !s1_done);
   assign accept    = req_valid && !req_stall;

   assign stored      = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rdata;
   assign stored_gen  = stored[MW-1:VW];
   assign stored_val  = stored[VW-1:0];
   assign fresh       = stored_gen == gen_count_ff;
   assign add_sum     = lfpat_pkg::sat_add(fresh ? stored_val : fill_value_ff, s1_operand_ff);
   assign read_result = (s1_in_range_ff && fresh) ? stored_val : fill_value_ff;

   assign ram_we    = clear_active_ff || s1_write;
   assign ram_waddr = clear_active_ff ? clear_addr_ff : s1_addr_ff;
   assign ram_wdata = clear_active_ff ? '0 : {gen_count_ff, add_sum};

   lfpat_ram #(
      .WIDTH (MW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      clear_active_in = clear_active_ff;
      clear_addr_in   = clear_addr_ff;
      if (clear_active_ff) begin
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == AW'(TABLE_DEPTH - 1)) begin
            clear_active_in = 1'b0;
         end
      end

      s1_valid_in    = accept || (s1_valid_ff && !s1_done);
      s1_op_in       = accept ? req_operation : s1_op_ff;
      s1_addr_in     = accept ? req_addr : s1_addr_ff;
      s1_in_range_in = accept ? req_in_range : s1_in_range_ff;
      s1_operand_in  = accept ? req_operand_value : s1_operand_ff;

      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      if (accept) begin
         fwd_valid_in = s1_write;
         fwd_addr_in  = s1_addr_ff;
         fwd_data_in  = {gen_count_ff, add_sum};
      end

      gen_count_in  = gen_count_ff;
      fill_value_in = fill_value_ff;
      wrap_flag_in  = wrap_flag_ff;
      if (s1_done && (s1_op_ff == lfpat_pkg::OP_FILL)) begin
         fill_value_in = s1_operand_ff;
         if (gen_count_ff == {GW{1'b1}}) begin
            gen_count_in = GW'(1);
            wrap_flag_in = 1'b1;
         end else begin
            gen_count_in = gen_count_ff + GW'(1);
         end
      end

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_value_in   = rsp_value_ff;
      rsp_wrapped_in = rsp_wrapped_ff;
      if (s1_done && (s1_op_ff == lfpat_pkg::OP_READ)) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = read_result;
         rsp_wrapped_in = wrap_flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         gen_count_ff    <= GW'(1);
         fill_value_ff   <= '0;
         wrap_flag_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         clear_active_ff <= clear_active_in;
         clear_addr_ff   <= clear_addr_in;
         s1_valid_ff     <= s1_valid_in;
         fwd_valid_ff    <= fwd_valid_in;
         gen_count_ff    <= gen_count_in;
         fill_value_ff   <= fill_value_in;
         wrap_flag_ff    <= wrap_flag_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      s1_op_ff       <= s1_op_in;
      s1_addr_ff     <= s1_addr_in;
      s1_in_range_ff <= s1_in_range_in;
      s1_operand_ff  <= s1_operand_in;
      fwd_addr_ff    <= fwd_addr_in;
      fwd_data_ff    <= fwd_data_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_wrapped_ff <= rsp_wrapped_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_read_value         = rsp_value_ff;
   assign rsp_generation_wrapped = rsp_wrapped_ff;

`ifndef SYNTHESIS
   a_no_transfer_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> req_stall)
      else $error("request transfer possible during the clearing pass");

   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> (ram_we && (ram_wdata == '0) && !s1_valid_ff))
      else $error("clearing pass overlaps table traffic");

   a_read_gives_response: assert property (@(posedge clock) disable iff (reset)
      (s1_done && (s1_op_ff == lfpat_pkg::OP_READ)) |=> rsp_valid_ff)
      else $error("completed read produced no response");

   a_generation_never_zero: assert property (@(posedge clock) disable iff (reset)
      gen_count_ff != '0)
      else $error("generation counter reached zero");

   a_wrap_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      wrap_flag_ff |=> wrap_flag_ff)
      else $error("wrap flag cleared without reset");
`endif

endmodule
